// File: src/ntpr_pkg.sv
`timescale 1ns / 1ps
// Package for the nearest-timer pulse-rate block: field widths, rate table
// constants and the table lookup function. No dependencies.
package ntpr_pkg;

	localparam int TimerWidth = 16;
	localparam int MinWidth   = 15;
	localparam int RateWidth  = 8;
	localparam int StepLog    = 3;
	localparam int IdxWidth   = 5;
	localparam int FracWidth  = StepLog;
	localparam int StepCount  = 1 << StepLog;
	localparam int RateEntries = 18;
	localparam int AccWidth   = 11;

	// Minimum value that stands for "no active timer".
	localparam logic [MinWidth-1:0] NO_ACTIVE_MIN = '1;
	// At or beyond this minimum the rate is fixed.
	localparam logic [MinWidth-1:0] FAR_THRESHOLD = MinWidth'((RateEntries - 1) * StepCount);
	localparam logic [RateWidth-1:0] FAR_RATE = RateWidth'(6);

	// Rate table, one entry every eight seconds.
	function automatic logic [RateWidth-1:0] rate_entry(input logic [IdxWidth-1:0] idx);
		logic [RateWidth-1:0] r;
		case (idx)
			5'd0:    r = 8'd200;
			5'd1:    r = 8'd144;
			5'd2:    r = 8'd106;
			5'd3:    r = 8'd79;
			5'd4:    r = 8'd60;
			5'd5:    r = 8'd46;
			5'd6:    r = 8'd36;
			5'd7:    r = 8'd29;
			5'd8:    r = 8'd23;
			5'd9:    r = 8'd19;
			5'd10:   r = 8'd16;
			5'd11:   r = 8'd13;
			5'd12:   r = 8'd11;
			5'd13:   r = 8'd10;
			5'd14:   r = 8'd9;
			5'd15:   r = 8'd8;
			5'd16:   r = 8'd7;
			5'd17:   r = 8'd7;
			default: r = FAR_RATE;
		endcase
		return r;
	endfunction

endpackage

// File: src/ntpr_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for timer beats and pulse-rate beats.
// Depends on ntpr_pkg for the field widths.
interface ntpr_timer_if;
	import ntpr_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [TimerWidth-1:0]  timer_value;
	logic                          last_timer;
	logic                          suppress;

	modport source (output valid, timer_value, last_timer, suppress, input ready);
	modport sink   (input valid, timer_value, last_timer, suppress, output ready);
endinterface

interface ntpr_pulse_if;
	import ntpr_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  pulse_on;
	logic [RateWidth-1:0]  pulse_rate;

	modport source (output valid, pulse_on, pulse_rate, input ready);
	modport sink   (input valid, pulse_on, pulse_rate, output ready);
endinterface

// File: src/nearest_timer_pulse_rate_top.sv
`timescale 1ns / 1ps
// Nearest-timer pulse-rate block: running minimum over a scan of timers and
// table interpolation of the LED pulse rate. Depends on ntpr_pkg, ntpr_if.
//
// Usage:
//   timers: one beat per countdown timer (signed seconds, negative means
//     inactive). last_timer marks the final beat of a scan; suppress on that
//     beat withholds the result. suppress on other beats is ignored.
//   pulse: one beat per unsuppressed scan. pulse_on = 0 with pulse_rate = 0
//     when no timer was active, else pulse_on = 1 with the rate (6..200).
// Result path: the edge that accepts the last beat of a scan loads the middle
//   stage; the interpolation of that minimum is then loaded into the output
//   register when the middle stage advances.
// Throughput: one timer beat per cycle while timers.ready is high; the
//   running-minimum compare is combinational and the interpolation stage holds a single entry.
// Reset: the running minimum returns to "no active timer", both stages empty.
// Stall: a held result stays in the output register; one more result may
//   wait in the middle stage, after which timers.ready drops until the
//   receiver takes the held beat. Timer beats without a result keep flowing
//   as long as the middle stage is empty or can advance.
module nearest_timer_pulse_rate_top (
	input  logic                clk,
	input  logic                arst_n,
	ntpr_timer_if.sink          timers,
	ntpr_pulse_if.source        pulse
);
	import ntpr_pkg::*;

	logic                  lower_min;
	logic [MinWidth-1:0]   run_min_q;
	logic [MinWidth-1:0]   new_min;
	logic                  tv_active;
	logic                  in_acc;
	logic                  take_result;

	logic                  v_s1;
	logic [MinWidth-1:0]   m_s1;
	logic                  out_free;
	logic                  adv_s1;

	logic                  out_valid_q;
	logic                  pulse_on_q;
	logic [RateWidth-1:0]  pulse_rate_q;

	logic [IdxWidth-1:0]   idx;
	logic [FracWidth-1:0]  frac;
	logic [RateWidth-1:0]  e0;
	logic [RateWidth-1:0]  e1;
	logic [FracWidth:0]    w0;
	logic [AccWidth-1:0]   acc;
	logic                  on_c;
	logic [RateWidth-1:0]  rate_c;

	// Handshake: the middle stage frees when it moves into the output register.
	assign out_free     = !out_valid_q || pulse.ready;
	assign adv_s1       = v_s1 && out_free;
	assign timers.ready = !v_s1 || out_free;
	assign in_acc       = timers.valid && timers.ready;
	assign take_result  = in_acc && timers.last_timer && !timers.suppress;

	// Fold the beat into the running minimum.
	assign tv_active = !timers.timer_value[TimerWidth-1];
	assign lower_min = tv_active && (timers.timer_value[MinWidth-1:0] < run_min_q);
	assign new_min   = lower_min ? timers.timer_value[MinWidth-1:0] : run_min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q <= NO_ACTIVE_MIN;
		end else if (in_acc) begin
			run_min_q <= timers.last_timer ? NO_ACTIVE_MIN : new_min;
		end
	end

	// Hold the scan minimum until the output register takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= (v_s1 && !adv_s1) || take_result;
		end
	end

	always_ff @(posedge clk) begin
		if (take_result) begin
			m_s1 <= new_min;
		end
	end

	// Interpolate between neighboring table entries in eighths.
	always_comb begin
		idx    = m_s1[StepLog+IdxWidth-1:StepLog];
		frac   = m_s1[FracWidth-1:0];
		e0     = rate_entry(idx);
		e1     = rate_entry(IdxWidth'(idx + IdxWidth'(1)));
		w0     = (FracWidth+1)'(StepCount) - {1'b0, frac};
		acc    = AccWidth'({3'b000, e0} * {7'b0000000, w0})
		       + AccWidth'({3'b000, e1} * {8'b00000000, frac});
		on_c   = (m_s1 != NO_ACTIVE_MIN);
		if (!on_c) begin
			rate_c = '0;
		end else if (m_s1 >= FAR_THRESHOLD) begin
			rate_c = FAR_RATE;
		end else begin
			rate_c = acc[StepLog+RateWidth-1:StepLog];
		end
	end

	// Output register: load on advance, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pulse_on_q   <= on_c;
			pulse_rate_q <= rate_c;
		end
	end

	assign pulse.valid      = out_valid_q;
	assign pulse.pulse_on   = pulse_on_q;
	assign pulse.pulse_rate = pulse_rate_q;

	// A scan end always restores the no-active minimum.
	a_min_restored: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && timers.last_timer |=> run_min_q == NO_ACTIVE_MIN)
		else $error("running minimum not restored after scan end");

	// The middle stage fills only from an unsuppressed scan end.
	a_s1_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s1) |-> $past(take_result))
		else $error("result stage filled without an unsuppressed last beat");

	// LED off carries a zero rate.
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pulse.valid && !pulse.pulse_on |-> pulse.pulse_rate == '0)
		else $error("nonzero rate with LED off");

	// LED on carries a rate within the table span.
	a_on_range: assert property (@(posedge clk) disable iff (!arst_n)
		pulse.valid && pulse.pulse_on |->
			pulse.pulse_rate >= FAR_RATE && pulse.pulse_rate <= RateWidth'(200))
		else $error("rate out of range with LED on");

endmodule
